[sv/tdct_pkg.sv]
// Shared types and constants for the tick deadline callback table.
// No dependencies; imported by every module of the block except tdct_ram.
package tdct_pkg;

    localparam int SLOTS  = 32;
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W  = $clog2(SLOTS + 1);

    localparam int TPS_W = 14;
    localparam logic [TPS_W-1:0] TPS_RESET = 14'd1024;

    // x / 1000 for any 32-bit x as (x * RECIP_MUL) >> RECIP_SHIFT (exact)
    localparam int MS_PER_SECOND = 1000;
    localparam int RECIP_SHIFT   = 38;
    localparam logic [31:0] RECIP_MUL =
        32'(((64'd1 << RECIP_SHIFT) + 64'(MS_PER_SECOND) - 64'd1) / 64'(MS_PER_SECOND));

    localparam logic OP_TICK     = 1'b0;
    localparam logic OP_REGISTER = 1'b1;

    typedef enum logic [1:0] {
        KIND_REGISTERED = 2'd0,
        KIND_REJECTED   = 2'd1,
        KIND_FIRED      = 2'd2,
        KIND_TICK_DONE  = 2'd3
    } kind_t;

    typedef struct packed {
        logic        opcode;
        logic [7:0]  handler_id;
        logic [31:0] arg_value;
        logic [31:0] wait_ms;
    } in_beat_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  fired_handler;
        logic [31:0] fired_arg;
        logic [31:0] time_value;
        logic        last;
    } out_beat_t;

    typedef struct packed {
        logic [31:0] deadline;
        logic [7:0]  handler;
        logic [31:0] arg;
    } slot_t;

    // controller -> datapath
    typedef struct packed {
        logic cap_in;     // capture input beat
        logic tick_start; // bump count, clear scan index
        logic mul1;       // wait_ms * ticks_per_second
        logic mul2;       // reciprocal multiply
        logic emit_reg;   // store slot, emit registered
        logic emit_rej;   // emit rejected
        logic rd_slot;    // read slot at scan index
        logic idx_inc;    // advance scan index
        logic emit_fire;  // emit fired, read last slot, shrink table
        logic move_wr;    // write moved slot at scan index
        logic emit_done;  // emit tick done
    } tdct_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic full;
        logic idx_lt_used;
        logic hit;
        logic out_free;
    } tdct_stat_t;

endpackage

[sv/tdct_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tdct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic                                       re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[sv/tdct_ctrl.sv]
// Sequencer for the alarm table: register path and tick scan.
// Depends on tdct_pkg; drives tdct_dp through tdct_cmd_t.
module tdct_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_opcode,
    output logic                in_ready,
    input  tdct_pkg::tdct_stat_t stat,
    output tdct_pkg::tdct_cmd_t  cmd
);
    import tdct_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL1,
        S_MUL2,
        S_ADD,
        S_REJECT,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_MOVE,
        S_DONE
    } state_t;

    state_t state_reg, state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.cap_in = 1'b1;
                    if (in_opcode == OP_TICK)
                    begin
                        cmd.tick_start = 1'b1;
                        state_next     = S_SCAN_RD;
                    end
                    else if (stat.full)
                    begin
                        state_next = S_REJECT;
                    end
                    else
                    begin
                        state_next = S_MUL1;
                    end
                end
            end
            S_MUL1:
            begin
                cmd.mul1   = 1'b1;
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                cmd.mul2   = 1'b1;
                state_next = S_ADD;
            end
            S_ADD:
            begin
                if (stat.out_free)
                begin
                    cmd.emit_reg = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_REJECT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit_rej = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_SCAN_RD:
            begin
                if (stat.idx_lt_used)
                begin
                    cmd.rd_slot = 1'b1;
                    state_next  = S_SCAN_CMP;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_SCAN_CMP:
            begin
                if (!stat.hit)
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = S_SCAN_RD;
                end
                else if (stat.out_free)
                begin
                    cmd.emit_fire = 1'b1;
                    state_next    = S_MOVE;
                end
            end
            S_MOVE:
            begin
                // moved entry sits in the read register: recheck it in place
                cmd.move_wr = 1'b1;
                state_next  = stat.idx_lt_used ? S_SCAN_CMP : S_DONE;
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.emit_done = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

[sv/tdct_dp.sv]
// Datapath: tick counter, table fill, deadline arithmetic, slot RAM, output register.
// Depends on tdct_pkg and tdct_ram; steered by tdct_ctrl.
module tdct_dp (
    input  logic                 clk,
    input  logic                 rst_n,
    input  tdct_pkg::in_beat_t   in_data,
    input  logic                 cfg_we,
    input  logic [tdct_pkg::TPS_W-1:0] cfg_wdata,
    output logic                 out_valid,
    input  logic                 out_ready,
    output tdct_pkg::out_beat_t  out_data,
    input  tdct_pkg::tdct_cmd_t  cmd,
    output tdct_pkg::tdct_stat_t stat
);
    import tdct_pkg::*;

    logic [TPS_W-1:0] tps_reg;
    logic [31:0]      count_reg;
    logic [CNT_W-1:0] used_reg;
    logic [CNT_W-1:0] idx_reg;
    in_beat_t         in_reg;
    logic [31:0]      prod_reg;
    logic [63:0]      recip_reg;
    logic             out_valid_reg;
    out_beat_t        out_reg;

    logic [45:0]      prod_full;
    logic [31:0]      deadline;
    logic [CNT_W-1:0] used_dec;
    logic             out_load;

    logic              ram_we;
    logic [SLOT_W-1:0] ram_waddr;
    slot_t             ram_wdata;
    logic              ram_re;
    logic [SLOT_W-1:0] ram_raddr;
    slot_t             ram_rdata;

    assign prod_full = 46'(in_reg.wait_ms) * 46'(tps_reg);
    assign deadline  = count_reg + 32'(recip_reg[63:RECIP_SHIFT]);
    assign used_dec  = used_reg - CNT_W'(1);
    assign out_load  = cmd.emit_reg | cmd.emit_rej | cmd.emit_fire | cmd.emit_done;

    assign stat.full        = (used_reg == CNT_W'(SLOTS));
    assign stat.idx_lt_used = (idx_reg < used_reg);
    assign stat.hit         = (ram_rdata.deadline < count_reg);
    assign stat.out_free    = !out_valid_reg || out_ready;

    // one write port: new alarm at the fill point, or moved entry at the scan index
    always_comb
    begin
        ram_we    = cmd.emit_reg | cmd.move_wr;
        ram_waddr = cmd.move_wr ? idx_reg[SLOT_W-1:0] : used_reg[SLOT_W-1:0];
        ram_wdata = cmd.move_wr ? ram_rdata
                                : slot_t'{deadline: deadline, handler: in_reg.handler_id,
                                          arg: in_reg.arg_value};
        ram_re    = cmd.rd_slot | cmd.emit_fire;
        ram_raddr = cmd.emit_fire ? used_dec[SLOT_W-1:0] : idx_reg[SLOT_W-1:0];
    end

    tdct_ram #(
        .WIDTH ($bits(slot_t)),
        .DEPTH (SLOTS)
    ) u_slots (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tps_reg       <= TPS_RESET;
            count_reg     <= '0;
            used_reg      <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                tps_reg <= cfg_wdata;
            end
            if (cmd.tick_start)
            begin
                count_reg <= count_reg + 32'd1;
                idx_reg   <= '0;
            end
            if (cmd.idx_inc)
            begin
                idx_reg <= idx_reg + CNT_W'(1);
            end
            if (cmd.emit_reg)
            begin
                used_reg <= used_reg + CNT_W'(1);
            end
            if (cmd.emit_fire)
            begin
                used_reg <= used_dec;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (cmd.cap_in)
        begin
            in_reg <= in_data;
        end
        if (cmd.mul1)
        begin
            prod_reg <= prod_full[31:0];
        end
        if (cmd.mul2)
        begin
            recip_reg <= 64'(prod_reg) * 64'(RECIP_MUL);
        end
        if (out_load)
        begin
            out_reg <= '0;
            if (cmd.emit_reg)
            begin
                out_reg.kind          <= KIND_REGISTERED;
                out_reg.fired_handler <= in_reg.handler_id;
                out_reg.time_value    <= deadline;
                out_reg.last          <= 1'b1;
            end
            else if (cmd.emit_rej)
            begin
                out_reg.kind          <= KIND_REJECTED;
                out_reg.fired_handler <= in_reg.handler_id;
                out_reg.last          <= 1'b1;
            end
            else if (cmd.emit_fire)
            begin
                out_reg.kind          <= KIND_FIRED;
                out_reg.fired_handler <= ram_rdata.handler;
                out_reg.fired_arg     <= ram_rdata.arg;
            end
            else
            begin
                out_reg.kind       <= KIND_TICK_DONE;
                out_reg.time_value <= count_reg;
                out_reg.last       <= 1'b1;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

`ifndef SYNTH
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!out_valid_reg || out_ready))
        else $error("output beat overwritten before taken");
    a_fire_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_fire |-> (used_reg != '0) && (idx_reg < used_reg))
        else $error("fire outside the used slots");
    a_reg_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_reg |-> (used_reg < CNT_W'(SLOTS)))
        else $error("store into a full table");
    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.idx_inc |=> (idx_reg <= used_reg))
        else $error("scan index ran past the fill point");
`endif

endmodule

[sv/tick_deadline_callback_table_unit.sv]
// Top level of the tick deadline callback table: one-shot alarm store and tick scan.
// Depends on tdct_pkg, tdct_ctrl, tdct_dp (which holds tdct_ram).
//
// A register beat (opcode 1) stores handler_id and arg_value in the next free
// slot with deadline = tick count + ((wait_ms * ticks_per_second) mod 2^32) / 1000,
// and answers one beat of kind registered carrying that deadline; if all SLOTS
// slots are taken it answers kind rejected and stores nothing. A register beat
// goes from accept to its answer through capture, the rate product, a
// reciprocal multiply that does the divide by 1000 exactly, then the add and
// slot write; a rejected one goes from capture straight to its answer. A tick
// beat (opcode 0) bumps the count and scans the used slots from index 0, one RAM
// read per slot: a slot whose deadline is below the new count (unsigned) emits a
// fired beat, the last used slot is moved into its place and checked again. A
// tick-done beat with the count closes the tick and is its only beat with last
// set; registered and rejected answers carry last as well. A kept slot costs a
// read and a compare, a fired slot a compare and a move, as the slot RAM has a
// single read and a single write port; out_ready stalls lengthen a tick. A new
// input beat is taken only once the previous one has emitted its last beat. One
// output register parts the sides, so an input can be accepted while the final
// result still waits for out_ready. ticks_per_second is written through
// cfg_we/cfg_wdata; the user must do so only while idle, which the block itself
// does not enforce. All 14-bit values are used as given. The slot RAM needs no
// clearing after reset.
module tick_deadline_callback_table_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  tdct_pkg::in_beat_t          in_data,
    output logic                        out_valid,
    input  logic                        out_ready,
    output tdct_pkg::out_beat_t         out_data,
    input  logic                        cfg_we,
    input  logic [tdct_pkg::TPS_W-1:0]  cfg_wdata
);
    import tdct_pkg::*;

    tdct_cmd_t  cmd;
    tdct_stat_t stat;

    // sequencer: one input beat in flight at a time
    tdct_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_opcode (in_data.opcode),
        .in_ready  (in_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // counter, fill point, arithmetic, slot RAM and output beat register
    tdct_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

[sim/tdct_checker.sv]
// Checker for the tick deadline callback table: tracks the alarm table, predicts result beats.
// Depends on tdct_pkg; instantiated by tb_top beside the block.
module tdct_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic                        in_ready,
    input  tdct_pkg::in_beat_t          in_data,
    input  logic                        out_valid,
    input  logic                        out_ready,
    input  tdct_pkg::out_beat_t         out_data,
    input  logic                        cfg_we,
    input  logic [tdct_pkg::TPS_W-1:0]  cfg_wdata,
    output int                          mismatch_count,
    output int                          pending
);
    import tdct_pkg::*;

    logic [TPS_W-1:0] rate_shadow;
    logic [31:0]      tick_total;
    int               alarms_used;
    logic [31:0]      alarm_deadline [SLOTS];
    logic [7:0]       alarm_handler  [SLOTS];
    logic [31:0]      alarm_arg      [SLOTS];

    out_beat_t        alarm_beats_due[$];
    out_beat_t        want;
    int               beats_seen;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] exp_val);
        $display("ERROR beat %0d: %s got %h want %h", beats_seen, what, got, exp_val);
        mismatch_count++;
    endtask

    // Applies one input beat to the shadow table and queues the beats it causes.
    task automatic run_alarm_table(input in_beat_t b);
        out_beat_t   r;
        logic [31:0] rate_prod;
        logic [31:0] deadline;
        int          i;
        if (b.opcode == OP_REGISTER)
        begin
            r = '0;
            r.fired_handler = b.handler_id;
            r.last = 1'b1;
            if (alarms_used >= SLOTS)
            begin
                r.kind = KIND_REJECTED;
            end
            else
            begin
                rate_prod = b.wait_ms * 32'(rate_shadow);
                deadline  = tick_total + rate_prod / 32'd1000;
                alarm_deadline[alarms_used] = deadline;
                alarm_handler[alarms_used]  = b.handler_id;
                alarm_arg[alarms_used]      = b.arg_value;
                alarms_used++;
                r.kind = KIND_REGISTERED;
                r.time_value = deadline;
            end
            alarm_beats_due.push_back(r);
        end
        else
        begin
            tick_total = tick_total + 32'd1;
            i = 0;
            while (i < alarms_used)
            begin
                if (alarm_deadline[i] < tick_total)
                begin
                    r = '0;
                    r.kind = KIND_FIRED;
                    r.fired_handler = alarm_handler[i];
                    r.fired_arg = alarm_arg[i];
                    alarm_beats_due.push_back(r);
                    // last used slot moves down and is checked again
                    alarms_used--;
                    alarm_deadline[i] = alarm_deadline[alarms_used];
                    alarm_handler[i]  = alarm_handler[alarms_used];
                    alarm_arg[i]      = alarm_arg[alarms_used];
                end
                else
                begin
                    i++;
                end
            end
            r = '0;
            r.kind = KIND_TICK_DONE;
            r.time_value = tick_total;
            r.last = 1'b1;
            alarm_beats_due.push_back(r);
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            rate_shadow    = TPS_RESET;
            tick_total     = '0;
            alarms_used    = 0;
            beats_seen     = 0;
            mismatch_count = 0;
            alarm_beats_due.delete();
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (alarm_beats_due.size() == 0)
                begin
                    report_mismatch("beat with nothing expected", 32'(out_data.kind), '0);
                end
                else
                begin
                    want = alarm_beats_due.pop_front();
                    if (out_data.kind !== want.kind)
                        report_mismatch("kind", 32'(out_data.kind), 32'(want.kind));
                    if (out_data.fired_handler !== want.fired_handler)
                        report_mismatch("fired_handler", 32'(out_data.fired_handler),
                                        32'(want.fired_handler));
                    if (out_data.fired_arg !== want.fired_arg)
                        report_mismatch("fired_arg", out_data.fired_arg, want.fired_arg);
                    if (out_data.time_value !== want.time_value)
                        report_mismatch("time_value", out_data.time_value, want.time_value);
                    if (out_data.last !== want.last)
                        report_mismatch("last", 32'(out_data.last), 32'(want.last));
                end
                beats_seen++;
            end
            if (in_valid && in_ready)
                run_alarm_table(in_data);
            if (cfg_we)
                rate_shadow = cfg_wdata;
        end
        pending = alarm_beats_due.size();
    end

endmodule

[sim/tb_top.sv]
// Testbench top for tick_deadline_callback_table_unit: stimulus, clock, reset, verdict.
// Depends on tdct_pkg, the block's RTL and tdct_checker (prediction and compare).
module tb_top;
    import tdct_pkg::*;

    // Watchdog limit; the slowest runs are full-table ticks with heavy stalls.
    localparam int LIMIT = 1000000;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             in_valid;
    logic             in_ready;
    in_beat_t         in_data;
    logic             out_valid;
    logic             out_ready = 1'b0;
    out_beat_t        out_data;
    logic             cfg_we;
    logic [TPS_W-1:0] cfg_wdata;

    int               mismatch_count;
    int               pending;
    int               cycle_cnt = 0;

    // Sender burst bookkeeping.
    int               burst_left = 0;

    // Receiver stall pattern state.
    int               ready_left = 0;
    int               ready_mode = 0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    tick_deadline_callback_table_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    tdct_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .in_data        (in_data),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_data       (out_data),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .mismatch_count (mismatch_count),
        .pending        (pending)
    );

    // Receiver: switches between stall styles at random intervals.
    //   mode 0: always ready (no backpressure stretch)
    //   mode 1: coin flip each cycle
    //   mode 2: one ready in four
    //   mode 3: long stalls, one ready in nine
    always @(negedge clk)
    begin
        if (ready_left == 0)
        begin
            ready_mode = $urandom_range(0, 3);
            ready_left = $urandom_range(8, 60);
        end
        ready_left--;
        case (ready_mode)
            0:       out_ready <= 1'b1;
            1:       out_ready <= 1'($urandom_range(0, 1));
            2:       out_ready <= (ready_left % 4 == 0);
            default: out_ready <= (ready_left % 9 == 0);
        endcase
    end

    // Watchdog: a hang or a lost beat ends here.
    initial
    begin
        while (cycle_cnt < LIMIT)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("== FAIL ==");
        $finish;
    end

    function automatic in_beat_t make_beat(input logic op, input logic [7:0] handler,
                                           input logic [31:0] arg, input logic [31:0] wait_ms);
        in_beat_t b;
        b.opcode     = op;
        b.handler_id = handler;
        b.arg_value  = arg;
        b.wait_ms    = wait_ms;
        return b;
    endfunction

    // Presents a beat at the falling edge and holds it until accepted.
    // Valid is left high; the caller either sends the next beat or drops it.
    task automatic send_beat(input in_beat_t b);
        in_valid = 1'b1;
        in_data  = b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Burst pacing: random-length bursts, random gaps, sometimes no gap at all.
    task automatic pace_sender();
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                in_valid = 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
    endtask

    // Stop sending and wait until every predicted beat has come back.
    task automatic drain_results();
        in_valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    // Rate register may only change while the block is idle.
    task automatic write_rate(input logic [TPS_W-1:0] rate);
        drain_results();
        cfg_we    = 1'b1;
        cfg_wdata = rate;
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    initial
    begin
        logic [TPS_W-1:0] rate_plan [9];
        logic [TPS_W-1:0] rate;
        logic [31:0]      wait_cap;
        logic [31:0]      wait_ms;
        int               reg_pct;

        in_valid  = 1'b0;
        in_data   = '0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        rst_n     = 1'b0;
        repeat (11) @(negedge clk);
        rst_n     = 1'b1;
        @(negedge clk);

        // --- Directed, rate at its reset value of 1024 ---
        // tick on an empty table
        send_beat(make_beat(OP_TICK, 8'h00, 32'h0, 32'h0));
        // deadline equal to the count: fires on the next tick
        send_beat(make_beat(OP_REGISTER, 8'h00, 32'h0000_0000, 32'd0));
        send_beat(make_beat(OP_REGISTER, 8'hFF, 32'hFFFF_FFFF, 32'd1));
        send_beat(make_beat(OP_REGISTER, 8'h5A, 32'hA5A5_A5A5, 32'd2000));
        // first slot fires, last slot moves into it and is checked again
        send_beat(make_beat(OP_TICK, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_beat(make_beat(OP_TICK, 8'h00, 32'h0, 32'h0));
        send_beat(make_beat(OP_TICK, 8'h00, 32'h0, 32'h0));
        // product overflow before the divide: 0xFFFFFFFF * 1024 wraps
        send_beat(make_beat(OP_REGISTER, 8'h81, 32'h8000_0001, 32'hFFFF_FFFF));
        send_beat(make_beat(OP_TICK, 8'h00, 32'h0, 32'h0));

        // --- Fill the table with rate 0 so every deadline equals the count ---
        write_rate('0);
        for (int k = 0; k < SLOTS - 1; k++)
        begin
            wait_ms = (k == 0) ? 32'hFFFF_FFFF : (k == 1) ? 32'd0 : $urandom;
            send_beat(make_beat(OP_REGISTER, 8'(k * 8 + 7), $urandom, wait_ms));
        end
        // table full: both of these come back rejected
        send_beat(make_beat(OP_REGISTER, 8'hFF, 32'hFFFF_FFFF, $urandom));
        send_beat(make_beat(OP_REGISTER, 8'h00, 32'h0, $urandom));
        // the two long-wait slots from the directed part are still parked; a rate-0 tick fires the rest
        send_beat(make_beat(OP_TICK, 8'h00, 32'h0, 32'h0));
        send_beat(make_beat(OP_TICK, 8'h00, 32'h0, 32'h0));

        // --- Random phases, one rate setting each, extremes included ---
        rate_plan[0] = 14'd16383;
        rate_plan[1] = 14'd2;
        rate_plan[2] = 14'd8192;
        rate_plan[3] = 14'd1;
        rate_plan[4] = 14'd1024;
        rate_plan[5] = 14'($urandom_range(0, 16383));
        rate_plan[6] = 14'($urandom_range(0, 16383));
        rate_plan[7] = 14'($urandom_range(0, 16383));
        rate_plan[8] = 14'd0;

        foreach (rate_plan[p])
        begin
            rate = rate_plan[p];
            write_rate(rate);
            // keep most deadlines within ~40 ticks so alarms actually fire
            wait_cap = (rate == 0) ? 32'hFFFF_FFFF : 32'd40000 / 32'(rate) + 32'd1;
            reg_pct  = $urandom_range(20, 85);
            for (int n = 0; n < 35; n++)
            begin
                pace_sender();
                if ($urandom_range(0, 49) == 0)
                    drain_results();
                if ($urandom_range(0, 99) < reg_pct)
                begin
                    // rare full-range waits: overflowing products and parked alarms
                    wait_ms = ($urandom_range(0, 24) == 0) ? $urandom
                                                          : $urandom_range(0, wait_cap);
                    send_beat(make_beat(OP_REGISTER, 8'($urandom), $urandom, wait_ms));
                end
                else
                begin
                    send_beat(make_beat(OP_TICK, 8'($urandom), $urandom, $urandom));
                end
            end
        end

        drain_results();
        repeat (20) @(negedge clk);
        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
